[sv/plgr_pkg.sv]
// Shared constants and types for the peak limiter with gain ramp.
// Used by the divider, queue, engine and top-level modules; no dependencies.
package plgr_pkg;

    localparam int DEFAULT_MAX_STEPS   = 16;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int        CFG_BITS   = 5;
    localparam logic [4:0] RAMP_RESET = 5'd4;

    localparam int UNITY    = 4096;     // 1.0 in Q4.12
    localparam int GAIN_ONE = 65536;    // 1.0 in Q0.16

    localparam int OUT_BITS    = 14;
    localparam int OUT_TDATA_W = 16;

    // Shared divider datapath width and the reciprocal dividend 4096*65536.
    localparam int          DIV_W          = 32;
    localparam logic [31:0] RECIP_DIVIDEND = 32'h1000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[sv/plgr_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on plgr_pkg for the datapath width and status struct.
module plgr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [plgr_pkg::DIV_W-1:0]     dividend,
    input  logic [plgr_pkg::DIV_W-1:0]     divisor,
    output logic [plgr_pkg::DIV_W-1:0]     quotient,
    output plgr_pkg::div_stat_t            stat
);
    localparam int W  = plgr_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[sv/plgr_queue.sv]
// Front end: two-entry queue that takes input transfers and holds them
// for the engine. Depends on plgr_pkg only for the default of WIDTH.
module plgr_queue #(
    parameter int WIDTH = plgr_pkg::DEFAULT_SAMPLE_BITS + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/plgr_engine.sv]
// Back end: sample window memory, peak search, gain ramp and output register.
// Depends on plgr_pkg and instantiates plgr_div.
module plgr_engine #(
    parameter int MAX_STEPS   = plgr_pkg::DEFAULT_MAX_STEPS,
    parameter int SAMPLE_BITS = plgr_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [plgr_pkg::CFG_BITS-1:0]       ramp_steps,
    input  logic                                q_valid,
    input  logic signed [SAMPLE_BITS-1:0]       q_sample,
    input  logic                                q_last,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [plgr_pkg::OUT_BITS-1:0] out_sample,
    output logic                                out_last
);
    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = 2 * MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_STEPS + 1);
    localparam int KW    = $clog2(MAX_STEPS + 2);
    localparam int PW    = SB + 17;
    localparam int OB    = plgr_pkg::OUT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_APPEND, ST_CHECK, ST_PEAK_RD, ST_DIV_G, ST_DIV_S,
        ST_NB, ST_NB_RD, ST_NB_WR, ST_POP, ST_POP_RD
    } state_t;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        return (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : AW'(s);
    endfunction

    state_t               state_reg, state_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        pidx_reg, pidx_next;
    logic signed [SB-1:0] smp_reg, smp_next;
    logic                 last_reg, last_next;
    logic [15:0]          g_reg, g_next;
    logic [16:0]          step_reg, step_next;
    logic [16:0]          gk_reg, gk_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 after_reg, after_next;
    logic [FW-1:0]        nbpos_reg, nbpos_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic                 nbneg_reg, nbneg_next;
    logic                 ovalid_reg, ovalid_next;
    logic [OB-1:0]        odata_reg, odata_next;
    logic                 olast_reg, olast_next;

    logic signed [SB-1:0] win_mem [DEPTH];
    logic signed [SB-1:0] rd_data_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic signed [SB-1:0] mem_wdata;

    logic                 div_start;
    logic [plgr_pkg::DIV_W-1:0] div_dividend, div_divisor, div_quo;
    plgr_pkg::div_stat_t  div_stat;

    logic [NW-1:0]        n_eff;
    logic [SB-1:0]        mag;
    logic [SB-1:0]        scaled;
    logic                 big;

    plgr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign n_eff = (32'(ramp_steps) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(ramp_steps);
    assign mag    = rd_data_reg[SB-1] ? SB'(-rd_data_reg) : SB'(rd_data_reg);
    assign big    = (longint'(rd_data_reg) > longint'(plgr_pkg::UNITY)) ||
                    (longint'(rd_data_reg) < -longint'(plgr_pkg::UNITY));
    assign scaled = prod_reg[SB+15:16];

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        fill_next    = fill_reg;
        pidx_next    = pidx_reg;
        smp_next     = smp_reg;
        last_next    = last_reg;
        g_next       = g_reg;
        step_next    = step_reg;
        gk_next      = gk_reg;
        k_next       = k_reg;
        after_next   = after_reg;
        nbpos_next   = nbpos_reg;
        prod_next    = prod_reg;
        nbneg_next   = nbneg_reg;
        ovalid_next  = (ovalid_reg && out_ready) ? 1'b0 : ovalid_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = wrap((AW+1)'(base_reg) + (AW+1)'(pidx_reg));
        mem_raddr    = wrap((AW+1)'(base_reg) + (AW+1)'(pidx_reg));
        mem_wdata    = smp_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = plgr_pkg::RECIP_DIVIDEND;
        div_divisor  = plgr_pkg::DIV_W'(mag);

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    smp_next   = q_sample;
                    last_next  = q_last;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (32'(fill_reg) < 32'(DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap((AW+1)'(base_reg) + (AW+1)'(fill_reg));
                    fill_next = fill_reg + FW'(1);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (last_reg ? (pidx_reg < fill_reg)
                             : (32'(fill_reg) - 32'(pidx_reg) > 32'(n_eff))) begin
                    mem_re     = 1'b1;
                    state_next = ST_PEAK_RD;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_PEAK_RD: begin
                if (big) begin
                    div_start  = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = rd_data_reg[SB-1] ? SB'(-plgr_pkg::UNITY)
                                                   : SB'(plgr_pkg::UNITY);
                    state_next = ST_DIV_G;
                end else begin
                    pidx_next  = pidx_reg + FW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_DIV_G: begin
                if (div_stat.done) begin
                    g_next       = div_quo[15:0];
                    div_start    = 1'b1;
                    div_dividend = 32'(plgr_pkg::GAIN_ONE) - 32'(div_quo[15:0]);
                    div_divisor  = 32'(n_eff) + 32'd1;
                    state_next   = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                if (div_stat.done) begin
                    step_next  = div_quo[16:0];
                    gk_next    = 17'(g_reg) + div_quo[16:0];
                    k_next     = KW'(1);
                    after_next = 1'b1;
                    state_next = ST_NB;
                end
            end
            ST_NB: begin
                if (32'(k_reg) > 32'(n_eff)) begin
                    pidx_next  = pidx_reg + FW'(1);
                    state_next = ST_CHECK;
                end else if (after_reg) begin
                    if (32'(pidx_reg) + 32'(k_reg) < 32'(fill_reg)) begin
                        nbpos_next = FW'(32'(pidx_reg) + 32'(k_reg));
                        mem_re     = 1'b1;
                        mem_raddr  = wrap((AW+1)'(base_reg) +
                                          (AW+1)'(32'(pidx_reg) + 32'(k_reg)));
                        state_next = ST_NB_RD;
                    end else begin
                        after_next = 1'b0;
                    end
                end else begin
                    if (32'(pidx_reg) >= 32'(k_reg)) begin
                        nbpos_next = FW'(32'(pidx_reg) - 32'(k_reg));
                        mem_re     = 1'b1;
                        mem_raddr  = wrap((AW+1)'(base_reg) +
                                          (AW+1)'(32'(pidx_reg) - 32'(k_reg)));
                        state_next = ST_NB_RD;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        gk_next    = gk_reg + step_reg;
                        after_next = 1'b1;
                    end
                end
            end
            ST_NB_RD: begin
                nbneg_next = rd_data_reg[SB-1];
                prod_next  = PW'(mag) * PW'(gk_reg);
                state_next = ST_NB_WR;
            end
            ST_NB_WR: begin
                mem_we    = 1'b1;
                mem_waddr = wrap((AW+1)'(base_reg) + (AW+1)'(nbpos_reg));
                mem_wdata = nbneg_reg ? SB'(-scaled) : SB'(scaled);
                if (after_reg) begin
                    after_next = 1'b0;
                end else begin
                    k_next     = k_reg + KW'(1);
                    gk_next    = gk_reg + step_reg;
                    after_next = 1'b1;
                end
                state_next = ST_NB;
            end
            ST_POP: begin
                if (last_reg ? (fill_reg != '0) : (32'(pidx_reg) > 32'(n_eff))) begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_reg;
                    state_next = ST_POP_RD;
                end else begin
                    if (last_reg) begin
                        fill_next = '0;
                        pidx_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_POP_RD: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next = 1'b1;
                    odata_next  = OB'(longint'(rd_data_reg));
                    olast_next  = last_reg && (fill_reg == FW'(1));
                    base_next   = wrap((AW+1)'(base_reg) + (AW+1)'(1));
                    fill_next   = fill_reg - FW'(1);
                    if (pidx_reg != '0) begin
                        pidx_next = pidx_reg - FW'(1);
                    end
                    state_next = ST_POP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            base_reg   <= '0;
            fill_reg   <= '0;
            pidx_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            fill_reg   <= fill_next;
            pidx_reg   <= pidx_next;
            ovalid_reg <= ovalid_next;
        end
        smp_reg   <= smp_next;
        last_reg  <= last_next;
        g_reg     <= g_next;
        step_reg  <= step_next;
        gk_reg    <= gk_next;
        k_reg     <= k_next;
        after_reg <= after_next;
        nbpos_reg <= nbpos_next;
        prod_reg  <= prod_next;
        nbneg_reg <= nbneg_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= win_mem[mem_raddr];
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_sample = odata_reg;
    assign out_last   = olast_reg;

`ifndef SYNTHESIS
    a_pidx_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        pidx_reg <= fill_reg)
        else $error("examined count beyond window fill");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= 32'(DEPTH))
        else $error("window fill beyond depth");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
    a_pop_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_RD && (!ovalid_reg || out_ready)) |=> ovalid_reg)
        else $error("popped sample not presented");
`endif

endmodule

[sv/peak_limiter_with_gain_ramp_core.sv]
// Top level of the peak limiter with gain ramp: config register, input queue
// and limiter engine. Depends on plgr_pkg, plgr_queue and plgr_engine.
//
// Usage:
//   s_axis_* carries one Q4.12 sample per transfer; s_axis_tlast marks the last
//   sample of a block and flushes every held sample. m_axis_* returns limited
//   samples in arrival order, m_axis_tlast on the final sample of a flush.
//   cfg_wr_en/cfg_wr_data write ramp_steps (N, reset 4, clamped to MAX_STEPS);
//   write it only while the block is idle.
// Latency and throughput:
//   A sample leaves 2N samples after it arrived (at once when N is 0). The
//   engine works one transfer at a time. Each peak runs two divides on the
//   shared serial divider (reciprocal gain, ramp step), then reads, scales and
//   writes back each ramped neighbor, up to 2N of them. The read-scale-write
//   pass over the window sets the neighbor rate, the shared serial divider the
//   peak cost.
// Reset: aresetn, synchronous, active low; clears the window, ramp_steps to 4.
// Stall: the output register holds a sample while m_axis_tready is low; the
//   two-entry input queue keeps accepting until it fills.
module peak_limiter_with_gain_ramp_core #(
    parameter int MAX_STEPS   = plgr_pkg::DEFAULT_MAX_STEPS,
    parameter int SAMPLE_BITS = plgr_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    // bits: sample_in, zero pad to whole bytes
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                                    s_axis_tlast,  // block_end
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // bits: sample_out [13:0], zero pad [15:14]
    output logic [plgr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast,  // is_last
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_wr_en,
    input  logic [plgr_pkg::CFG_BITS-1:0]           cfg_wr_data
);
    localparam int QW = SAMPLE_BITS + 1;

    logic [plgr_pkg::CFG_BITS-1:0] ramp_steps_reg, ramp_steps_next;
    logic [QW-1:0]                 q_data;
    logic                          q_valid, q_pop;
    logic signed [plgr_pkg::OUT_BITS-1:0] out_sample;

    // Hold the ramp length until a write transfer replaces it.
    assign ramp_steps_next = cfg_wr_en ? cfg_wr_data : ramp_steps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_steps_reg <= plgr_pkg::RAMP_RESET;
        end else begin
            ramp_steps_reg <= ramp_steps_next;
        end
    end

    // Front: queue each input transfer as {block_end, sample}.
    plgr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  ({s_axis_tlast, s_axis_tdata[SAMPLE_BITS-1:0]}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    // Back: window, peak gain and ramp, output register.
    plgr_engine #(
        .MAX_STEPS   (MAX_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ramp_steps (ramp_steps_reg),
        .q_valid    (q_valid),
        .q_sample   (q_data[SAMPLE_BITS-1:0]),
        .q_last     (q_data[SAMPLE_BITS]),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast)
    );

    // Pad the result to a whole number of bytes.
    assign m_axis_tdata = {{(plgr_pkg::OUT_TDATA_W - plgr_pkg::OUT_BITS){1'b0}}, out_sample};

endmodule

[sim/peak_limiter_with_gain_ramp_checker.sv]
// Scoreboard for the peak limiter core: watches the sample, result and config ports,
// predicts every released sample and compares it field by field.
// Depends on plgr_pkg for the port widths.
module peak_limiter_with_gain_ramp_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [15:0]                         s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [plgr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [plgr_pkg::CFG_BITS-1:0]       cfg_wr_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked,
    output int                                  peaks_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXN  = plgr_pkg::DEFAULT_MAX_STEPS;
    localparam int DEPTH = 2 * MAXN + 1;

    typedef struct packed {
        logic [13:0] sample;
        logic        last;
    } limited_t;

    longint   held [DEPTH];
    int       held_count;
    int       scan_pos;
    logic [4:0] steps_reg;
    limited_t released_q [$];

    function automatic longint apply_gain(longint s, longint gain);
        longint m;
        m = (s < 0) ? -s : s;
        m = (m * gain) / plgr_pkg::GAIN_ONE;
        return (s < 0) ? -m : m;
    endfunction

    function automatic void limit_at(int pos, int n);
        longint x, mag, g, stp, gk;
        x = held[pos];
        if (x <= plgr_pkg::UNITY && x >= -plgr_pkg::UNITY) return;
        peaks_seen++;
        mag = (x < 0) ? -x : x;
        g = (longint'(plgr_pkg::UNITY) * plgr_pkg::GAIN_ONE) / mag;
        stp = (plgr_pkg::GAIN_ONE - g) / (n + 1);
        held[pos] = (x > 0) ? plgr_pkg::UNITY : -plgr_pkg::UNITY;
        for (int k = 1; k <= n; k++) begin
            gk = g + k * stp;
            if (pos + k < held_count) held[pos + k] = apply_gain(held[pos + k], gk);
            if (pos >= k) held[pos - k] = apply_gain(held[pos - k], gk);
        end
    endfunction

    function automatic void release_oldest(logic last);
        limited_t r;
        r.sample = held[0][13:0];
        r.last = last;
        released_q.push_back(r);
        for (int i = 0; i < DEPTH - 1; i++) held[i] = held[i + 1];
        held[DEPTH - 1] = 0;
        held_count--;
        if (scan_pos > 0) scan_pos--;
    endfunction

    function automatic void take_sample(logic [15:0] raw, logic block_end);
        int n;
        n = (steps_reg > MAXN) ? MAXN : int'(steps_reg);
        if (held_count < DEPTH) begin
            held[held_count] = longint'($signed(raw));
            held_count++;
        end
        if (block_end) begin
            // flush: examine everything, then empty the window
            while (scan_pos < held_count) begin
                limit_at(scan_pos, n);
                scan_pos++;
            end
            while (held_count > 0) release_oldest(held_count == 1);
            scan_pos = 0;
            return;
        end
        while (held_count - scan_pos > n) begin
            limit_at(scan_pos, n);
            scan_pos++;
        end
        while (scan_pos > n && held_count > 0) release_oldest(1'b0);
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
        peaks_seen = 0;
    end

    always @(posedge aclk) begin
        limited_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) held[i] = 0;
            held_count = 0;
            scan_pos = 0;
            steps_reg = plgr_pkg::RAMP_RESET;
            released_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                checked++;
                if (released_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result data=%h last=%b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = released_q.pop_front();
                    if (m_axis_tdata !== {2'b00, want.sample} || m_axis_tlast !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: result %0d expected %h/%b got %h/%b", checked,
                                     {2'b00, want.sample}, want.last,
                                     m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tlast);
            if (cfg_wr_en) steps_reg = cfg_wr_data;
        end
        pending = released_q.size();
    end
endmodule

[sim/peak_limiter_with_gain_ramp_core_tb.sv]
// Testbench top for the peak limiter core: clock, reset, sample stimulus,
// output back-pressure and the verdict. Depends on plgr_pkg and the checker.
module peak_limiter_with_gain_ramp_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 3000;   // settling time before a ramp write and at the end

    logic        aclk;
    logic        aresetn;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [plgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_wr_en;
    logic [plgr_pkg::CFG_BITS-1:0] cfg_wr_data;

    int fail_count, pending, checked, peaks_seen;
    int sent, blocks, cycles;
    int send_idle, recv_idle;

    peak_limiter_with_gain_ramp_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    peak_limiter_with_gain_ramp_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending),
        .checked(checked), .peaks_seen(peaks_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: drop tready at random per the current idle rate.
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // Pick the idle rates from how far the stimulus has got.
    always @(negedge aclk) begin
        if (sent < 90) begin
            send_idle <= 9;  recv_idle <= 71;
        end else if (sent < 180) begin
            send_idle <= 71; recv_idle <= 9;
        end else begin
            send_idle <= 0;  recv_idle <= 0;
        end
    end

    // Drive one sample transfer and hold it until accepted.
    task automatic push_sample(logic [15:0] value, logic block_end);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tlast  = block_end;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        sent++;
        if (block_end) blocks++;
    endtask

    // Hold off until every released sample is back, let the engine settle,
    // then write ramp_steps.
    task automatic write_steps(logic [4:0] n);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = n;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 16'($signed($urandom_range(8192)) - 4096);
        if (r < 80) begin
            // peak: magnitude above 1.0
            if ($urandom_range(1)) return 16'($urandom_range(32767, 4097));
            return 16'(-$signed($urandom_range(32768, 4097)));
        end
        return 16'($urandom);
    endfunction

    logic [15:0] corner [10] = '{16'd0, 16'd4096, -16'sd4096, 16'd4097, -16'sd4097,
                                 16'h7fff, 16'h8000, 16'd1, 16'hffff, 16'd100};
    logic [4:0] step_menu [8] = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd17, 5'd31};

    initial begin
        int len, cut;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle = 9;
        recv_idle = 71;
        sent = 0;
        blocks = 0;
        cycles = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: corner samples with the reset ramp of 4, then a lone peak.
        foreach (corner[i]) push_sample(corner[i], i == 9);
        push_sample(16'h8000, 1'b1);
        // No ramp: each peak is limited alone, its neighbors pass unchanged.
        write_steps(5'd0);
        push_sample(16'd9000, 1'b0);
        push_sample(-16'sd5000, 1'b0);
        push_sample(16'd300, 1'b1);
        // Oversized ramp acts as the maximum.
        write_steps(5'd31);
        for (int i = 0; i < 6; i++) push_sample(i == 2 ? 16'h7fff : 16'd2000, i == 5);
        write_steps(5'd16);

        // Random blocks, changing the ramp between most of them.
        while (sent < 245) begin
            len = $urandom_range(1, 30);
            cut = (blocks == 12) ? len / 2 : -1;
            for (int i = 0; i < len; i++) begin
                // once: change the ramp in the middle of a block
                if (i == cut && i > 0) write_steps(5'($urandom_range(0, 16)));
                push_sample(pick_sample(), i == len - 1);
            end
            if ($urandom_range(3) != 0)
                write_steps($urandom_range(1) ? step_menu[$urandom_range(7)]
                                              : 5'($urandom_range(31)));
        end

        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        $display("Covered %0d samples in %0d blocks, %0d peaks limited, %0d results checked.",
                 sent, blocks, peaks_seen, checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
